>>> hw/rtl/swt_pkg.sv
// Shared types, codes and stage tables for the staged watchdog timer.
// No dependencies; used by every module of the block.
package swt_pkg;

	localparam int unsigned NUM_STAGES   = 8;
	localparam int unsigned NUM_REGS     = 8;
	localparam int unsigned LIMIT_W      = 32;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam logic        CACHE_ORDER_DEF = 1'b0;

	localparam logic [2:0] LAST_POS = 3'd7;

	localparam logic [2:0] REQ_TICK      = 3'd0;
	localparam logic [2:0] REQ_TRANS     = 3'd1;
	localparam logic [2:0] REQ_STOP      = 3'd2;
	localparam logic [2:0] REQ_HEARTBEAT = 3'd3;
	localparam logic [2:0] REQ_START     = 3'd4;

	localparam logic [2:0] REG_ENABLE = 3'd0;

	typedef enum logic [1:0] {
		MODE_STOPPED  = 2'd0,
		MODE_RUNNING  = 2'd1,
		MODE_TIMEDOUT = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_TRANS,
		OP_STOP,
		OP_HEARTBEAT,
		OP_START,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] code;
	} cmd_t;

	typedef logic [NUM_REGS-1:0][LIMIT_W-1:0] limits_t;

	localparam logic [2:0] PLAIN_ORDER [NUM_STAGES] = '{3'd0, 3'd1, 3'd2, 3'd3,
		3'd4, 3'd5, 3'd6, 3'd7};
	localparam logic [2:0] CACHE_ORDER_TBL [NUM_STAGES] = '{3'd0, 3'd1, 3'd5, 3'd2,
		3'd3, 3'd4, 3'd6, 3'd7};
	// register holding the limit for reaching each stage code; 0 means no limit reg
	localparam logic [2:0] LIMIT_REG [NUM_STAGES] = '{3'd0, 3'd1, 3'd2, 3'd4,
		3'd5, 3'd3, 3'd6, 3'd7};

	function automatic logic [2:0] stage_at(input logic cache, input logic [2:0] pos);
		return cache ? CACHE_ORDER_TBL[pos] : PLAIN_ORDER[pos];
	endfunction

	function automatic logic [2:0] limit_reg_of(input logic [2:0] stage);
		return LIMIT_REG[stage];
	endfunction

endpackage

>>> hw/rtl/swt_front.sv
// Front end: takes request words, decodes them into commands, holds one in a stage.
// Depends on swt_pkg.
module swt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [2:0]    req_type,
	input  logic [2:0]    stage_code,
	output logic          push,
	output swt_pkg::cmd_t push_cmd,
	input  logic          q_full
);
	import swt_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t dec;
	logic take;

	always_comb begin
		dec.code = stage_code;
		case (req_type)
			REQ_TICK:      dec.op = OP_TICK;
			REQ_TRANS:     dec.op = OP_TRANS;
			REQ_STOP:      dec.op = OP_STOP;
			REQ_HEARTBEAT: dec.op = OP_HEARTBEAT;
			REQ_START:     dec.op = OP_START;
			default:       dec.op = OP_NOP;
		endcase
	end

	assign push     = valid_s1 && !q_full;
	assign push_cmd = cmd_s1;
	assign in_stall = valid_s1 && q_full;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= dec;
		end
	end

endmodule

>>> hw/rtl/swt_queue.sv
// Short command queue between the front end and the watchdog back end.
// Depends on swt_pkg.
module swt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swt_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output swt_pkg::cmd_t head
);
	import swt_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> hw/rtl/swt_back.sv
// Back end: run state, stage position and elapsed counter, timeout check, status register.
// Depends on swt_pkg.
module swt_back #(
	parameter logic CACHE_ORDER = swt_pkg::CACHE_ORDER_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  swt_pkg::cmd_t    head,
	output logic             pop,
	input  logic             enable,
	input  swt_pkg::limits_t limits,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       run_state,
	output logic [2:0]       current_stage,
	output logic [2:0]       stage_position,
	output logic [31:0]      remaining_ticks,
	output logic             timeout_armed,
	output logic             order_error
);
	import swt_pkg::*;

	mode_t               mode_q;
	logic [2:0]          pos_q;
	logic [LIMIT_W-1:0]  elapsed_q;

	mode_t               n_mode;
	logic [2:0]          n_pos;
	logic [LIMIT_W-1:0]  n_el;
	logic                err;
	logic [LIMIT_W-1:0]  limit;
	logic                armed;
	logic                expired;
	logic                fire;

	logic                out_valid_q;
	mode_t               mode_out_q;
	logic [2:0]          pos_out_q;
	logic [LIMIT_W-1:0]  remaining_q;
	logic                armed_q;
	logic                err_q;

	always_comb begin
		n_mode = mode_q;
		n_pos  = pos_q;
		n_el   = elapsed_q;
		err    = 1'b0;
		case (head.op)
			OP_TICK: begin
				if (elapsed_q != '1) begin
					n_el = elapsed_q + 1'b1;
				end
			end
			OP_TRANS: begin
				if (mode_q == MODE_RUNNING) begin
					if (pos_q == LAST_POS) begin
						err = 1'b1;
					end else begin
						err   = (stage_at(CACHE_ORDER, pos_q + 3'd1) != head.code);
						n_pos = pos_q + 3'd1;
					end
					n_el = '0;
				end
			end
			OP_STOP: begin
				if (mode_q == MODE_RUNNING) begin
					n_mode = MODE_STOPPED;
				end
			end
			OP_HEARTBEAT: begin
				n_el = '0;
			end
			OP_START: begin
				n_mode = enable ? MODE_RUNNING : MODE_STOPPED;
				n_pos  = '0;
				n_el   = '0;
			end
			default: begin
			end
		endcase
	end

	assign limit   = limits[limit_reg_of(stage_at(CACHE_ORDER, n_pos + 3'd1))];
	assign armed   = (n_mode == MODE_RUNNING) && (n_pos != LAST_POS);
	assign expired = armed && (n_el >= limit);
	assign fire    = q_not_empty && (!out_valid_q || !out_stall);
	assign pop     = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STOPPED;
			pos_q       <= '0;
			elapsed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				mode_q    <= expired ? MODE_TIMEDOUT : n_mode;
				pos_q     <= n_pos;
				elapsed_q <= n_el;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mode_out_q  <= expired ? MODE_TIMEDOUT : n_mode;
			pos_out_q   <= n_pos;
			remaining_q <= (armed && !expired) ? limit - n_el : '0;
			armed_q     <= armed && !expired;
			err_q       <= err;
		end
	end

	assign out_valid       = out_valid_q;
	assign run_state       = mode_out_q;
	assign stage_position  = pos_out_q;
	assign current_stage   = stage_at(CACHE_ORDER, pos_out_q);
	assign remaining_ticks = remaining_q;
	assign timeout_armed   = armed_q;
	assign order_error     = err_q;

endmodule

>>> hw/rtl/staged_watchdog_timer_top.sv
// Top level of the staged watchdog timer: configuration registers, front, queue, back.
// Depends on swt_pkg, swt_front, swt_queue, swt_back.
// Takes one request word per cycle when not stalled and returns one status word per request,
// in order. A request passes the front stage register, queue and status register; the state
// update and the timeout compare on the selected stage limit run in the back end, which sets
// the rate of one word per cycle while out_stall is low. Configuration writes take effect
// at the next edge; the user must make them while no word is in flight, unchecked here.
module staged_watchdog_timer_top #(
	parameter logic CACHE_ORDER = swt_pkg::CACHE_ORDER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [2:0]  stage_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  run_state,
	output logic [2:0]  current_stage,
	output logic [2:0]  stage_position,
	output logic [31:0] remaining_ticks,
	output logic        timeout_armed,
	output logic        order_error
);
	import swt_pkg::*;

	logic    enable_q;
	limits_t limit_q;
	limits_t limits;
	logic    push;
	cmd_t    push_cmd;
	logic    q_full;
	logic    q_not_empty;
	logic    pop;
	cmd_t    head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			limit_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_ENABLE) begin
				enable_q <= cfg_wdata[0];
			end else begin
				limit_q[cfg_index] <= cfg_wdata;
			end
		end
	end

	always_comb begin
		limits             = limit_q;
		limits[REG_ENABLE] = '0;
	end

	swt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.stage_code (stage_code),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_full     (q_full)
	);

	swt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	swt_back #(
		.CACHE_ORDER (CACHE_ORDER)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_not_empty     (q_not_empty),
		.head            (head),
		.pop             (pop),
		.enable          (enable_q),
		.limits          (limits),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.run_state       (run_state),
		.current_stage   (current_stage),
		.stage_position  (stage_position),
		.remaining_ticks (remaining_ticks),
		.timeout_armed   (timeout_armed),
		.order_error     (order_error)
	);

`ifndef SYNTHESIS
	a_armed_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timeout_armed |->
			(run_state == MODE_RUNNING) && (stage_position != LAST_POS))
		else $error("armed status outside running state or at last stage");

	a_armed_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timeout_armed |-> remaining_ticks != '0)
		else $error("armed status with no ticks remaining");

	a_idle_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !timeout_armed |-> remaining_ticks == '0)
		else $error("remaining ticks reported while not armed");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty)
		else $error("queue popped while empty");
`endif

endmodule
